// ===== hdl/tlbpid_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbpid_pkg
// Shared constants, command codes and cell interface types for the
// pid-tagged LRU translation buffer.
// ----------------------------------------------------------------------------
package tlbpid_pkg;

	localparam int TLB_DEPTH = 16;
	localparam int IDX_W     = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
	localparam int CFG_W     = 5;
	localparam int CMP_W     = ((CFG_W > IDX_W) ? CFG_W : IDX_W) + 1;
	localparam int TAG_W     = 16;
	localparam int STAMP_W   = 32;
	localparam int OUT_IDX_W = 4;

	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	// commands
	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_FLUSH  = 2'd2;
	localparam logic [1:0] CMD_REMOVE = 2'd3;

	// commit operations broadcast to the cells
	localparam logic [1:0] WR_STAMP = 2'd0;
	localparam logic [1:0] WR_FILL  = 2'd1;
	localparam logic [1:0] WR_DROP  = 2'd2;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [TAG_W-1:0] pid;
		logic [TAG_W-1:0] page;
		logic [TAG_W-1:0] frame;
	} req_t;

	// record carried from cell to cell during a sweep
	typedef struct packed {
		logic               tok;
		logic               found;
		logic [IDX_W-1:0]   found_idx;
		logic [TAG_W-1:0]   found_frame;
		logic               free_set;
		logic [IDX_W-1:0]   free_idx;
		logic               lru_set;
		logic [IDX_W-1:0]   lru_idx;
		logic [STAMP_W-1:0] lru_stamp;
		logic [TAG_W-1:0]   lru_pid;
		logic [TAG_W-1:0]   lru_page;
		logic [TAG_W-1:0]   lru_frame;
	} acc_t;

	typedef struct packed {
		logic               en;
		logic [1:0]         op;
		logic [IDX_W-1:0]   idx;
		logic [TAG_W-1:0]   pid;
		logic [TAG_W-1:0]   page;
		logic [TAG_W-1:0]   frame;
		logic [STAMP_W-1:0] stamp;
	} wr_t;

endpackage

// ===== hdl/tlb_lru_pid_tagged.sv =====
// ----------------------------------------------------------------------------
// tlb_lru_pid_tagged
// Fully associative translation buffer tagged by pid and page, with LRU
// replacement, built as a chain of entry cells swept by a search record.
//
//   channel   signals                                   direction
//   input     in_valid/in_ready, command pid page frame  in
//   output    out_valid/out_ready, hit ... evicted_frame out
//   config    cfg_we, cfg_wdata (entries_in_use)         in
//
// an item goes through an accept, a walk of the search record along the
// chain, one cell at a time, and a commit
// the commit waits while the output register still holds an untaken result
// a new item is accepted as soon as the commit is done
// reset clears all valid bits, the use clock and sets entries_in_use to 16
// ----------------------------------------------------------------------------
module tlb_lru_pid_tagged import tlbpid_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           command,
	input  logic [TAG_W-1:0]     pid,
	input  logic [TAG_W-1:0]     page,
	input  logic [TAG_W-1:0]     frame,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 hit,
	output logic [OUT_IDX_W-1:0] entry_index,
	output logic [TAG_W-1:0]     hit_frame,
	output logic                 inserted,
	output logic                 evicted,
	output logic [TAG_W-1:0]     evicted_pid,
	output logic [TAG_W-1:0]     evicted_page,
	output logic [TAG_W-1:0]     evicted_frame
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_DONE  = 2'd2;

	logic [1:0]         state_q;
	logic [IDX_W-1:0]   cnt_q;
	req_t               req_q;
	logic [CFG_W-1:0]   cfg_q;
	logic [STAMP_W-1:0] use_clock_q;
	logic               out_valid_q;

	logic                 hit_q, inserted_q, evicted_q;
	logic [OUT_IDX_W-1:0] entry_index_q;
	logic [TAG_W-1:0]     hit_frame_q, evicted_pid_q, evicted_page_q, evicted_frame_q;

	logic                 hit_d, inserted_d, evicted_d;
	logic [OUT_IDX_W-1:0] entry_index_d;
	logic [TAG_W-1:0]     hit_frame_d, evicted_pid_d, evicted_page_d, evicted_frame_d;
	logic                 take_stamp;

	acc_t acc_head;
	acc_t chain [TLB_DEPTH+1];
	acc_t tail;
	wr_t  wr;
	logic load;
	logic in_xfer;
	logic last_cell;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign last_cell = (cnt_q == IDX_W'(TLB_DEPTH - 1));
	assign load      = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		acc_head     = '0;
		acc_head.tok = (state_q == ST_SWEEP) && (cnt_q == '0);
	end

	assign chain[0] = acc_head;
	assign tail     = chain[TLB_DEPTH];

	for (genvar i = 0; i < TLB_DEPTH; i++) begin : g_cell
		tlbpid_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cell_idx(IDX_W'(i)),
			.cfg     (cfg_q),
			.req     (req_q),
			.wr      (wr),
			.acc_in  (chain[i]),
			.acc_out (chain[i+1])
		);
	end

	// commit: result fields and the single entry write
	always_comb begin
		hit_d           = 1'b0;
		entry_index_d   = '0;
		hit_frame_d     = '0;
		inserted_d      = 1'b0;
		evicted_d       = 1'b0;
		evicted_pid_d   = '0;
		evicted_page_d  = '0;
		evicted_frame_d = '0;
		take_stamp      = 1'b0;
		wr              = '0;
		wr.pid          = req_q.pid;
		wr.page         = req_q.page;
		wr.frame        = req_q.frame;
		wr.stamp        = use_clock_q;
		if (cfg_q != '0) begin
			case (req_q.cmd)
				CMD_LOOKUP: begin
					if (tail.found) begin
						hit_d         = 1'b1;
						entry_index_d = OUT_IDX_W'(tail.found_idx);
						hit_frame_d   = tail.found_frame;
						take_stamp    = 1'b1;
						wr.en         = 1'b1;
						wr.op         = WR_STAMP;
						wr.idx        = tail.found_idx;
					end
				end
				CMD_INSERT: begin
					if (tail.found) begin
						hit_d         = 1'b1;
						entry_index_d = OUT_IDX_W'(tail.found_idx);
						hit_frame_d   = tail.found_frame;
					end else begin
						inserted_d = 1'b1;
						take_stamp = 1'b1;
						wr.en      = 1'b1;
						wr.op      = WR_FILL;
						if (tail.free_set) begin
							wr.idx = tail.free_idx;
						end else begin
							wr.idx          = tail.lru_idx;
							evicted_d       = 1'b1;
							evicted_pid_d   = tail.lru_pid;
							evicted_page_d  = tail.lru_page;
							evicted_frame_d = tail.lru_frame;
						end
						entry_index_d = OUT_IDX_W'(wr.idx);
					end
				end
				CMD_REMOVE: begin
					if (tail.found) begin
						hit_d         = 1'b1;
						entry_index_d = OUT_IDX_W'(tail.found_idx);
						hit_frame_d   = tail.found_frame;
						wr.en         = 1'b1;
						wr.op         = WR_DROP;
						wr.idx        = tail.found_idx;
					end
				end
				default: begin
					// flush is done by the cells during the sweep
				end
			endcase
		end
		wr.en = wr.en && load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			cfg_q       <= CFG_RESET;
			use_clock_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_SWEEP;
						cnt_q   <= '0;
					end
				end
				ST_SWEEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_cell) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
						if (take_stamp && use_clock_q != '1) begin
							use_clock_q <= use_clock_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q.cmd   <= command;
			req_q.pid   <= pid;
			req_q.page  <= page;
			req_q.frame <= frame;
		end
		if (load) begin
			hit_q           <= hit_d;
			entry_index_q   <= entry_index_d;
			hit_frame_q     <= hit_frame_d;
			inserted_q      <= inserted_d;
			evicted_q       <= evicted_d;
			evicted_pid_q   <= evicted_pid_d;
			evicted_page_q  <= evicted_page_d;
			evicted_frame_q <= evicted_frame_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign entry_index   = entry_index_q;
	assign hit_frame     = hit_frame_q;
	assign inserted      = inserted_q;
	assign evicted       = evicted_q;
	assign evicted_pid   = evicted_pid_q;
	assign evicted_page  = evicted_page_q;
	assign evicted_frame = evicted_frame_q;

	a_evict_is_insert: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && evicted_q |-> inserted_q)
		else $error("eviction reported without an insert");

	a_hit_not_insert: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(hit_q && inserted_q))
		else $error("insert reported as both hit and written");

	a_clock_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> use_clock_q >= $past(use_clock_q))
		else $error("use clock went backward");

	a_sweep_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == ST_SWEEP && cnt_q == '0)
		else $error("sweep did not start after input transfer");

	a_tail_arrives: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP && last_cell |=> tail.tok)
		else $error("search record did not reach the end of the chain");

endmodule

// ===== hdl/tlbpid_cell.sv =====
// ----------------------------------------------------------------------------
// tlbpid_cell
// One translation entry. Folds its own tag, free state and stamp into the
// sweep record passed on to the next cell, and applies commit writes and flushes.
// ----------------------------------------------------------------------------
module tlbpid_cell import tlbpid_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] cell_idx,
	input  logic [CFG_W-1:0] cfg,
	input  req_t             req,
	input  wr_t              wr,
	input  acc_t             acc_in,
	output acc_t             acc_out
);

	logic               valid_q;
	logic [TAG_W-1:0]   pid_q;
	logic [TAG_W-1:0]   page_q;
	logic [TAG_W-1:0]   frame_q;
	logic [STAMP_W-1:0] stamp_q;
	logic               tok_q;
	acc_t               data_q;
	acc_t               acc_d;
	logic               en;
	logic               pid_eq;
	logic               match;
	logic               wr_hit;
	logic               flush_hit;

	assign en        = CMP_W'(cfg) > CMP_W'(cell_idx);
	assign pid_eq    = valid_q && en && (pid_q == req.pid);
	assign match     = pid_eq && (page_q == req.page);
	assign wr_hit    = wr.en && (wr.idx == cell_idx);
	assign flush_hit = acc_in.tok && (req.cmd == CMD_FLUSH) && pid_eq;

	always_comb begin
		acc_d = acc_in;
		if (en) begin
			if (match && !acc_in.found) begin
				acc_d.found       = 1'b1;
				acc_d.found_idx   = cell_idx;
				acc_d.found_frame = frame_q;
			end
			if (!valid_q && !acc_in.free_set) begin
				acc_d.free_set = 1'b1;
				acc_d.free_idx = cell_idx;
			end
			// strict compare keeps the lowest index on a tie
			if (valid_q && (!acc_in.lru_set || stamp_q < acc_in.lru_stamp)) begin
				acc_d.lru_set   = 1'b1;
				acc_d.lru_idx   = cell_idx;
				acc_d.lru_stamp = stamp_q;
				acc_d.lru_pid   = pid_q;
				acc_d.lru_page  = page_q;
				acc_d.lru_frame = frame_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= 1'b0;
		end else begin
			tok_q <= acc_in.tok;
			if (flush_hit) begin
				valid_q <= 1'b0;
			end else if (wr_hit && wr.op == WR_FILL) begin
				valid_q <= 1'b1;
			end else if (wr_hit && wr.op == WR_DROP) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in.tok) begin
			data_q <= acc_d;
		end
		if (wr_hit && wr.op == WR_FILL) begin
			pid_q   <= wr.pid;
			page_q  <= wr.page;
			frame_q <= wr.frame;
		end
		if (wr_hit && (wr.op == WR_FILL || wr.op == WR_STAMP)) begin
			stamp_q <= wr.stamp;
		end
	end

	always_comb begin
		acc_out     = data_q;
		acc_out.tok = tok_q;
	end

endmodule

// ===== verif/tb_tlb_lru_pid_tagged.sv =====
// ----------------------------------------------------------------------------
// tb_tlb_lru_pid_tagged
// Self-checking bench for the pid-tagged LRU translation buffer. A shadow
// copy of the entry table predicts every response: lookup, insert with fill
// or LRU eviction, pid flush and single remove. Each response is compared
// field by field. Directed items come first, then random phases under
// several entries_in_use settings, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_tlb_lru_pid_tagged;
	import tlbpid_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                 hit;
		logic [OUT_IDX_W-1:0] idx;
		logic [TAG_W-1:0]     hit_frame;
		logic                 inserted;
		logic                 evicted;
		logic [TAG_W-1:0]     ev_pid;
		logic [TAG_W-1:0]     ev_page;
		logic [TAG_W-1:0]     ev_frame;
	} tlb_result_t;

	// shadow of the entry table plus the queue of responses still owed
	class tlb_scoreboard;
		bit [CFG_W-1:0]   entries_cfg;
		bit               ent_valid [TLB_DEPTH];
		bit [TAG_W-1:0]   ent_pid   [TLB_DEPTH];
		bit [TAG_W-1:0]   ent_page  [TLB_DEPTH];
		bit [TAG_W-1:0]   ent_frame [TLB_DEPTH];
		bit [STAMP_W-1:0] ent_stamp [TLB_DEPTH];
		bit [STAMP_W-1:0] use_clock;
		tlb_result_t      owed_results[$];
		int               errors;

		function new();
			entries_cfg = CFG_RESET;
			use_clock = '0;
			errors = 0;
			foreach (ent_valid[i]) begin
				ent_valid[i] = 1'b0;
			end
		endfunction

		function void set_entries(bit [CFG_W-1:0] value);
			entries_cfg = value;
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		function bit [STAMP_W-1:0] next_stamp();
			bit [STAMP_W-1:0] s;
			s = use_clock;
			// the clock sticks at all ones
			if (use_clock != '1)
				use_clock = use_clock + 1'b1;
			return s;
		endfunction

		function int find_pair(int n, bit [TAG_W-1:0] p, bit [TAG_W-1:0] pg);
			for (int i = 0; i < n; i++) begin
				if (ent_valid[i] && ent_pid[i] == p && ent_page[i] == pg)
					return i;
			end
			return -1;
		endfunction

		function tlb_result_t translate(bit [1:0] cmd, bit [TAG_W-1:0] p,
				bit [TAG_W-1:0] pg, bit [TAG_W-1:0] fr);
			tlb_result_t r;
			int n;
			int k;
			int slot;
			r = '0;
			n = (entries_cfg > TLB_DEPTH) ? TLB_DEPTH : int'(entries_cfg);
			if (n == 0)
				return r;
			k = find_pair(n, p, pg);
			case (cmd)
				CMD_LOOKUP: begin
					if (k >= 0) begin
						ent_stamp[k] = next_stamp();
						r.hit = 1'b1;
						r.idx = k[OUT_IDX_W-1:0];
						r.hit_frame = ent_frame[k];
					end
				end
				CMD_INSERT: begin
					if (k >= 0) begin
						// already present: no write, no stamp refresh
						r.hit = 1'b1;
						r.idx = k[OUT_IDX_W-1:0];
						r.hit_frame = ent_frame[k];
					end else begin
						slot = -1;
						for (int i = 0; i < n; i++) begin
							if (!ent_valid[i] && slot < 0)
								slot = i;
						end
						if (slot < 0) begin
							// oldest stamp, lowest index on a tie
							slot = 0;
							for (int i = 1; i < n; i++) begin
								if (ent_stamp[i] < ent_stamp[slot])
									slot = i;
							end
							r.evicted = 1'b1;
							r.ev_pid = ent_pid[slot];
							r.ev_page = ent_page[slot];
							r.ev_frame = ent_frame[slot];
						end
						ent_valid[slot] = 1'b1;
						ent_pid[slot] = p;
						ent_page[slot] = pg;
						ent_frame[slot] = fr;
						ent_stamp[slot] = next_stamp();
						r.idx = slot[OUT_IDX_W-1:0];
						r.inserted = 1'b1;
					end
				end
				CMD_FLUSH: begin
					for (int i = 0; i < n; i++) begin
						if (ent_valid[i] && ent_pid[i] == p)
							ent_valid[i] = 1'b0;
					end
				end
				CMD_REMOVE: begin
					if (k >= 0) begin
						ent_valid[k] = 1'b0;
						r.hit = 1'b1;
						r.idx = k[OUT_IDX_W-1:0];
						r.hit_frame = ent_frame[k];
					end
				end
			endcase
			return r;
		endfunction

		function void accept_request(bit [1:0] cmd, bit [TAG_W-1:0] p,
				bit [TAG_W-1:0] pg, bit [TAG_W-1:0] fr);
			owed_results.push_back(translate(cmd, p, pg, fr));
		endfunction

		task report_mismatch(string what);
			errors++;
			$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_response(tlb_result_t got);
			tlb_result_t want;
			if (owed_results.size() == 0) begin
				report_mismatch("response with nothing outstanding");
				return;
			end
			want = owed_results.pop_front();
			if (got.hit !== want.hit)
				report_mismatch($sformatf("hit exp %0h got %0h", want.hit, got.hit));
			if (got.idx !== want.idx)
				report_mismatch($sformatf("entry_index exp %0h got %0h", want.idx, got.idx));
			if (got.hit_frame !== want.hit_frame)
				report_mismatch($sformatf("hit_frame exp %0h got %0h",
					want.hit_frame, got.hit_frame));
			if (got.inserted !== want.inserted)
				report_mismatch($sformatf("inserted exp %0h got %0h",
					want.inserted, got.inserted));
			if (got.evicted !== want.evicted)
				report_mismatch($sformatf("evicted exp %0h got %0h",
					want.evicted, got.evicted));
			if (got.ev_pid !== want.ev_pid)
				report_mismatch($sformatf("evicted_pid exp %0h got %0h",
					want.ev_pid, got.ev_pid));
			if (got.ev_page !== want.ev_page)
				report_mismatch($sformatf("evicted_page exp %0h got %0h",
					want.ev_page, got.ev_page));
			if (got.ev_frame !== want.ev_frame)
				report_mismatch($sformatf("evicted_frame exp %0h got %0h",
					want.ev_frame, got.ev_frame));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           command;
	logic [TAG_W-1:0]     pid;
	logic [TAG_W-1:0]     page;
	logic [TAG_W-1:0]     frame;
	logic                 out_valid;
	logic                 out_ready;
	logic                 hit;
	logic [OUT_IDX_W-1:0] entry_index;
	logic [TAG_W-1:0]     hit_frame;
	logic                 inserted;
	logic                 evicted;
	logic [TAG_W-1:0]     evicted_pid;
	logic [TAG_W-1:0]     evicted_page;
	logic [TAG_W-1:0]     evicted_frame;

	tlb_scoreboard sb = new();
	bit            tx_burst;

	tlb_lru_pid_tagged DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.pid           (pid),
		.page          (page),
		.frame         (frame),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.hit           (hit),
		.entry_index   (entry_index),
		.hit_frame     (hit_frame),
		.inserted      (inserted),
		.evicted       (evicted),
		.evicted_pid   (evicted_pid),
		.evicted_page  (evicted_page),
		.evicted_frame (evicted_frame)
	);

	always #5 clk = ~clk;

	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function int pick_gap();
		int r;
		if (tx_burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// called at a rising edge, returns at the edge of the transfer
	task send_request(bit [1:0] cmd, bit [TAG_W-1:0] p, bit [TAG_W-1:0] pg,
			bit [TAG_W-1:0] fr);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		pid <= p;
		page <= pg;
		frame <= fr;
		do @(posedge clk); while (!in_ready);
		sb.accept_request(cmd, p, pg, fr);
	endtask

	// small tag pools so lookups hit and inserts collide
	task send_random();
		int r;
		bit [1:0] cmd;
		bit [TAG_W-1:0] p;
		bit [TAG_W-1:0] pg;
		bit [TAG_W-1:0] fr;
		fr = TAG_W'($urandom_range(0, 65535));
		if ($urandom_range(0, 9) == 0) begin
			cmd = 2'($urandom_range(0, 3));
			p = TAG_W'($urandom_range(0, 65535));
			pg = TAG_W'($urandom_range(0, 65535));
		end else begin
			case ($urandom_range(0, 3))
				0: p = 16'h0000;
				1: p = 16'hFFFF;
				2: p = 16'h00A5;
				default: p = 16'h5A00;
			endcase
			pg = TAG_W'($urandom_range(0, 5));
			if (pg == 5)
				pg = 16'hFFFF;
			r = $urandom_range(0, 99);
			if (r < 40)
				cmd = CMD_LOOKUP;
			else if (r < 75)
				cmd = CMD_INSERT;
			else if (r < 92)
				cmd = CMD_REMOVE;
			else
				cmd = CMD_FLUSH;
		end
		send_request(cmd, p, pg, fr);
	endtask

	task wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_entries(bit [CFG_W-1:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		sb.set_entries(value);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// response side: random ready, one long hold-off to back up the input
	initial begin
		int stall;
		int mode;
		int mode_left;
		int taken;
		stall = 0;
		mode = 0;
		mode_left = 0;
		taken = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				sb.check_response({hit, entry_index, hit_frame, inserted, evicted,
					evicted_pid, evicted_page, evicted_frame});
				taken++;
				if (taken == 150)
					stall = 300;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 80);
			end else begin
				mode_left--;
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 9) < 7);
					2: out_ready <= ($urandom_range(0, 9) < 3);
					default: begin
						if ($urandom_range(0, 29) == 0)
							stall = $urandom_range(15, 50);
						out_ready <= ($urandom_range(0, 9) < 8);
					end
				endcase
			end
		end
	end

	initial begin
		int phase_cfg [6];
		int phase_len [6];
		phase_cfg = '{1, 31, 6, 0, 16, 9};
		phase_len = '{80, 80, 80, 20, 80, 80};
		phase_cfg[5] = $urandom_range(0, 31);
		tx_burst = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		command <= CMD_LOOKUP;
		pid <= '0;
		page <= '0;
		frame <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_entries(5'd16);
		send_request(CMD_INSERT, 16'h0000, 16'h0000, 16'h0000);
		send_request(CMD_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(CMD_LOOKUP, 16'h0000, 16'h0000, 16'h0000);
		send_request(CMD_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0000);
		send_request(CMD_LOOKUP, 16'h0000, 16'hFFFF, 16'h0000);
		send_request(CMD_INSERT, 16'h0000, 16'h0000, 16'h1234);
		send_request(CMD_REMOVE, 16'hFFFF, 16'hFFFF, 16'h0000);
		send_request(CMD_REMOVE, 16'hFFFF, 16'hFFFF, 16'h0000);
		send_request(CMD_INSERT, 16'h0001, 16'h0002, 16'hAAAA);
		send_request(CMD_FLUSH,  16'h0000, 16'h0000, 16'h0000);
		send_request(CMD_LOOKUP, 16'h0000, 16'h0000, 16'h0000);

		// three entries: fill, then evict by age after a refresh
		write_entries(5'd3);
		send_request(CMD_INSERT, 16'h0005, 16'h0001, 16'h1111);
		send_request(CMD_INSERT, 16'h0005, 16'h0002, 16'h2222);
		send_request(CMD_INSERT, 16'h0006, 16'h0003, 16'h3333);
		send_request(CMD_LOOKUP, 16'h0005, 16'h0001, 16'h0000);
		send_request(CMD_INSERT, 16'h0006, 16'h0004, 16'h4444);
		send_request(CMD_FLUSH,  16'h0005, 16'h0000, 16'h0000);

		// disabled table answers all zeros
		write_entries(5'd0);
		send_request(CMD_LOOKUP, 16'h0006, 16'h0003, 16'h0000);
		send_request(CMD_INSERT, 16'h0007, 16'h0007, 16'h0007);
		send_request(CMD_REMOVE, 16'h0006, 16'h0003, 16'h0000);
		send_request(CMD_FLUSH,  16'h0006, 16'h0000, 16'h0000);

		// oversized setting acts as the full depth
		write_entries(5'd31);
		send_request(CMD_LOOKUP, 16'h0006, 16'h0003, 16'h0000);
		send_request(CMD_INSERT, 16'hFFFF, 16'h0000, 16'h5555);
		send_request(CMD_LOOKUP, 16'h0001, 16'h0002, 16'h0000);
		send_request(CMD_REMOVE, 16'h0006, 16'h0004, 16'h0000);

		for (int ph = 0; ph < 6; ph++) begin
			write_entries(CFG_W'(phase_cfg[ph]));
			tx_burst = (ph % 3 == 2);
			for (int i = 0; i < phase_len[ph]; i++)
				send_random();
		end

		wait_idle();
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/tlbpid_pkg.sv
hdl/tlbpid_cell.sv
hdl/tlb_lru_pid_tagged.sv
verif/tb_tlb_lru_pid_tagged.sv
